// ===== rtl/core/mmbd_pkg.sv =====
// Package for the min/max bucket downsampler: widths, register indexes,
// point kinds, the back-end phase type and the queue entry flags.
// No dependencies; every other file of the block but mmbd_if uses it.
`timescale 1ns / 1ps
`default_nettype none

package mmbd_pkg;

   localparam int DEF_COORD_WIDTH = 32;
   localparam int DEF_FRAC_BITS   = 16;

   localparam int LEN_W       = 16;
   localparam int POS_W       = 16;
   localparam int THRESH_W    = 31;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 31;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_BUCKET_LENGTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DROP_THRESHOLD = 2'd1;

   typedef enum logic [1:0] {
      KIND_FIRST  = 2'd0,
      KIND_TROUGH = 2'd1,
      KIND_PEAK   = 2'd2
   } point_kind_type;

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_TROUGH,
      PH_PEAK
   } phase_type;

   typedef struct packed {
      logic first;
      logic extremes;
   } emit_type;

   localparam int EMIT_W = $bits(emit_type);

endpackage

`default_nettype wire

// ===== rtl/core/mmbd_if.sv =====
// Valid/ready channel interfaces for the sample stream and the point stream.
// Depends on nothing; the width of the coordinates is a parameter.
`timescale 1ns / 1ps
`default_nettype none

interface mmbd_req_if #(
   parameter int COORD_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic        [COORD_WIDTH-1:0] sample_x;
   logic signed [COORD_WIDTH-1:0] sample_y;
   logic                          last_sample;

   modport source (output valid, output sample_x, output sample_y, output last_sample,
                   input ready);
   modport sink   (input valid, input sample_x, input sample_y, input last_sample,
                   output ready);
endinterface

interface mmbd_rsp_if #(
   parameter int COORD_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic        [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic        [1:0]             point_kind;
   logic                          run_end;

   modport source (output valid, output point_x, output point_y, output point_kind,
                   output run_end, input ready);
   modport sink   (input valid, input point_x, input point_y, input point_kind,
                   input run_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mmbd_front.sv =====
// Front end: configuration registers, sample acceptance, bucket position and
// extreme tracking, and the decision which points a sample causes.
// Depends on mmbd_pkg and mmbd_req_if.
`timescale 1ns / 1ps
`default_nettype none

module mmbd_front #(
   parameter int COORD_WIDTH = mmbd_pkg::DEF_COORD_WIDTH,
   parameter int FRAC_BITS   = mmbd_pkg::DEF_FRAC_BITS
) (
   input  wire logic                                            clock,
   input  wire logic                                            reset,
   mmbd_req_if.sink                                             req,
   input  wire logic                                            csr_we,
   input  wire logic [mmbd_pkg::CSR_INDEX_W-1:0]                csr_index,
   input  wire logic [mmbd_pkg::CSR_DATA_W-1:0]                 csr_wdata,
   output logic                                                 push_valid,
   output logic [6*COORD_WIDTH+mmbd_pkg::EMIT_W-1:0]            push_data,
   input  wire logic                                            q_full
);
   import mmbd_pkg::*;

   localparam int CmpW = (COORD_WIDTH > THRESH_W) ? COORD_WIDTH : THRESH_W;
   localparam logic [THRESH_W-1:0] ThreshReset =
      THRESH_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

   logic [LEN_W-1:0]       len_ff;
   logic [THRESH_W-1:0]    thr_ff;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [COORD_WIDTH-1:0] lo_y_ff, lo_y_in, lo_x_ff, lo_x_in;
   logic [COORD_WIDTH-1:0] hi_y_ff, hi_y_in, hi_x_ff, hi_x_in;
   logic                   st_valid_ff, st_valid_in;
   logic [COORD_WIDTH-1:0] st_x_ff, st_y_ff;
   logic                   st_first_ff, st_close_ff;

   logic [LEN_W-1:0]       len_eff;
   logic [POS_W:0]         pos_inc;
   logic                   first, close, lt, gt;
   logic [COORD_WIDTH-1:0] range;
   logic                   over, need_push, st_take, accept;
   emit_type               emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_W'(1);
         thr_ff <= ThreshReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BUCKET_LENGTH:  len_ff <= csr_wdata[LEN_W-1:0];
            CSR_DROP_THRESHOLD: thr_ff <= csr_wdata[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      len_eff = (len_ff == '0) ? LEN_W'(1) : len_ff;
      pos_inc = {1'b0, pos_ff} + (POS_W+1)'(1);
      first   = (pos_ff == '0);
      close   = req.last_sample || (pos_inc[POS_W-1:0] >= len_eff) || pos_inc[POS_W];
      lt      = $signed(req.sample_y) < $signed(lo_y_ff);
      gt      = $signed(req.sample_y) > $signed(hi_y_ff);

      range     = hi_y_ff - lo_y_ff;
      over      = CmpW'(range) > CmpW'(thr_ff);
      need_push = st_first_ff || (st_close_ff && over);
      st_take   = st_valid_ff && (!need_push || !q_full);
      req.ready = !st_valid_ff || st_take;
      accept    = req.valid && req.ready;

      emit.first    = st_first_ff;
      emit.extremes = st_close_ff && over;
      push_valid    = st_valid_ff && need_push && !q_full;
      push_data     = {emit, st_x_ff, st_y_ff, lo_x_ff, lo_y_ff, hi_x_ff, hi_y_ff};

      pos_in  = close ? '0 : pos_inc[POS_W-1:0];
      lo_y_in = (first || lt) ? req.sample_y : lo_y_ff;
      lo_x_in = (first || lt) ? req.sample_x : lo_x_ff;
      hi_y_in = (first || gt) ? req.sample_y : hi_y_ff;
      hi_x_in = (first || gt) ? req.sample_x : hi_x_ff;

      priority if (accept) begin
         st_valid_in = 1'b1;
      end else if (st_take) begin
         st_valid_in = 1'b0;
      end else begin
         st_valid_in = st_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= 1'b0;
         pos_ff      <= '0;
         lo_y_ff     <= '0;
         lo_x_ff     <= '0;
         hi_y_ff     <= '0;
         hi_x_ff     <= '0;
      end else begin
         st_valid_ff <= st_valid_in;
         if (accept) begin
            pos_ff  <= pos_in;
            lo_y_ff <= lo_y_in;
            lo_x_ff <= lo_x_in;
            hi_y_ff <= hi_y_in;
            hi_x_ff <= hi_x_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         st_x_ff     <= req.sample_x;
         st_y_ff     <= req.sample_y;
         st_first_ff <= first;
         st_close_ff <= close;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/mmbd_queue.sv =====
// Short first-in first-out queue of point events between front and back end.
// Depends on mmbd_pkg for the default depth.
`timescale 1ns / 1ps
`default_nettype none

module mmbd_queue #(
   parameter int DATA_W = 194,
   parameter int DEPTH  = mmbd_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   input  wire logic [DATA_W-1:0] push_data,
   output logic                   full,
   input  wire logic              pop,
   output logic                   valid,
   output logic [DATA_W-1:0]      data
);
   localparam int AddrW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountW = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [AddrW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   always_comb begin
      full    = (count_ff == CountW'(DEPTH));
      valid   = (count_ff != '0);
      data    = slot_ff[rd_ptr_ff];
      do_push = push_valid && !full;
      do_pop  = pop && valid;

      wr_ptr_in = wr_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AddrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AddrW'(1);
      end
      rd_ptr_in = rd_ptr_ff;
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AddrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AddrW'(1);
      end

      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CountW'(1);
         2'b01:   count_in = count_ff - CountW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/mmbd_back.sv =====
// Back end: takes point events from the queue and sends their points one per
// transfer: bucket first sample, then trough and peak. Depends on mmbd_pkg, mmbd_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module mmbd_back #(
   parameter int COORD_WIDTH = mmbd_pkg::DEF_COORD_WIDTH
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       q_valid,
   input  wire logic [6*COORD_WIDTH+mmbd_pkg::EMIT_W-1:0]  q_data,
   output logic                                            q_pop,
   mmbd_rsp_if.source                                      rsp
);
   import mmbd_pkg::*;

   localparam int EvW = 6*COORD_WIDTH + EMIT_W;

   logic [EvW-1:0]         ev_ff;
   logic                   hold_valid_ff, hold_valid_in;
   phase_type              phase_ff, phase_in, start_phase;
   emit_type               ev_emit, q_emit;
   logic [COORD_WIDTH-1:0] ev_x, ev_y, ev_lo_x, ev_lo_y, ev_hi_x, ev_hi_y;
   logic                   last_point, advance, load;

   assign {ev_emit, ev_x, ev_y, ev_lo_x, ev_lo_y, ev_hi_x, ev_hi_y} = ev_ff;
   assign q_emit = emit_type'(q_data[EvW-1 -: EMIT_W]);

   always_comb begin
      last_point  = (phase_ff == PH_PEAK) || (phase_ff == PH_FIRST && !ev_emit.extremes);
      advance     = hold_valid_ff && rsp.ready && last_point;
      load        = q_valid && (!hold_valid_ff || advance);
      q_pop       = load;
      start_phase = q_emit.first ? PH_FIRST : PH_TROUGH;

      priority if (load) begin
         hold_valid_in = 1'b1;
      end else if (advance) begin
         hold_valid_in = 1'b0;
      end else begin
         hold_valid_in = hold_valid_ff;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      priority if (load) begin
         phase_in = start_phase;
      end else if (hold_valid_ff && rsp.ready && !last_point) begin
         unique case (phase_ff)
            PH_FIRST:  phase_in = PH_TROUGH;
            PH_TROUGH: phase_in = PH_PEAK;
            PH_PEAK:   phase_in = PH_PEAK;
            default:   phase_in = PH_FIRST;
         endcase
      end else begin
         phase_in = phase_ff;
      end
   end

   always_comb begin
      rsp.valid   = hold_valid_ff;
      rsp.run_end = last_point;
      unique case (phase_ff)
         PH_FIRST: begin
            rsp.point_x    = ev_x;
            rsp.point_y    = ev_y;
            rsp.point_kind = KIND_FIRST;
         end
         PH_TROUGH: begin
            rsp.point_x    = ev_lo_x;
            rsp.point_y    = ev_lo_y;
            rsp.point_kind = KIND_TROUGH;
         end
         PH_PEAK: begin
            rsp.point_x    = ev_hi_x;
            rsp.point_y    = ev_hi_y;
            rsp.point_kind = KIND_PEAK;
         end
         default: begin
            rsp.point_x    = ev_x;
            rsp.point_y    = ev_y;
            rsp.point_kind = KIND_FIRST;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         phase_ff      <= PH_FIRST;
      end else begin
         hold_valid_ff <= hold_valid_in;
         phase_ff      <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ev_ff <= q_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/min_max_bucket_downsampler_core.sv =====
// Top level of the min/max bucket downsampler: front end, event queue and
// back end. Depends on mmbd_pkg, mmbd_if, mmbd_front, mmbd_queue, mmbd_back.
//
//   Channel  Direction  Handshake        Carries
//   req      in         valid / ready    sample_x, sample_y, last_sample
//   rsp      out        valid / ready    point_x, point_y, point_kind, run_end
//   csr      in         csr_we           csr_index, csr_wdata
//
// One sample is accepted per cycle while no event waits on a full queue; its points
// pass the front-end stage register, the event queue and the back-end event register
// to rsp, one point per cycle while rsp.ready is high. A four-entry event queue
// separates the two ends. Reset is synchronous and clears the position, extremes,
// queue and registers. A stall on rsp fills the queue, after which req.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module min_max_bucket_downsampler_core #(
   parameter int COORD_WIDTH = mmbd_pkg::DEF_COORD_WIDTH,
   parameter int FRAC_BITS   = mmbd_pkg::DEF_FRAC_BITS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   mmbd_req_if.sink                              req,
   mmbd_rsp_if.source                            rsp,
   input  wire logic                             csr_we,
   input  wire logic [mmbd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [mmbd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import mmbd_pkg::*;

   localparam int EvW = 6*COORD_WIDTH + EMIT_W;

   logic           push_valid, q_full, q_pop, q_valid;
   logic [EvW-1:0] push_data, q_data;

   mmbd_front #(
      .COORD_WIDTH(COORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .push_valid(push_valid),
      .push_data (push_data),
      .q_full    (q_full)
   );

   mmbd_queue #(
      .DATA_W(EvW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .data      (q_data)
   );

   mmbd_back #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .q_valid(q_valid),
      .q_data (q_data),
      .q_pop  (q_pop),
      .rsp    (rsp)
   );

endmodule

`default_nettype wire

// ===== rtl/core/mmbd_checker.sv =====
// Port-level checks on the point stream of the downsampler, and the bind
// that attaches them to the top level. Depends on mmbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmbd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_point_kind,
   input wire logic       rsp_run_end
);
   import mmbd_pkg::*;

   // A point waiting on the port stays until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped before transfer");

   // The peak always ends the run of points of its sample.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_point_kind == KIND_PEAK |-> rsp_run_end)
      else $error("peak point without run_end");

   // A trough is followed directly by its peak.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_point_kind == KIND_TROUGH
      |-> !rsp_run_end ##1 (rsp_valid && rsp_point_kind == KIND_PEAK))
      else $error("trough not followed by peak");

   // A first-sample point that does not end its run is followed by a trough.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_point_kind == KIND_FIRST && !rsp_run_end
      |=> rsp_valid && rsp_point_kind == KIND_TROUGH)
      else $error("first point not followed by trough");

   // The unused kind code never appears.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_point_kind == KIND_FIRST || rsp_point_kind == KIND_TROUGH ||
                     rsp_point_kind == KIND_PEAK))
      else $error("invalid point kind");

endmodule

bind min_max_bucket_downsampler_core mmbd_checker u_mmbd_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_point_kind(rsp.point_kind),
   .rsp_run_end   (rsp.run_end)
);

`default_nettype wire

// ===== dv/min_max_bucket_downsampler_core_test.sv =====
// Self-checking test of min_max_bucket_downsampler_core: a bucket tracker class
// predicts the first, trough and peak points that each sample causes and checks each
// point transfer. Depends on mmbd_pkg, mmbd_if and the core itself.
`timescale 1ns / 1ps

module min_max_bucket_downsampler_core_test;
   import mmbd_pkg::*;

   localparam int CW = DEF_COORD_WIDTH;
   localparam int DROP_RESET = ((1 << DEF_FRAC_BITS) + 5) / 10;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;
   localparam logic [THRESH_W-1:0] DROP_MAX = {THRESH_W{1'b1}};
   localparam int PHASES = 7;
   localparam int PHASE_ITEMS = 60;
   localparam int DRAIN_LIMIT = 5000;
   localparam int QUIET_CYCLES = 12;
   localparam int RUN_LIMIT_NS = 2_000_000;

   typedef struct {
      logic [CW-1:0]        x;
      logic signed [CW-1:0] y;
      point_kind_type       kind;
      logic                 run_end;
   } point_type;

   class bucket_tracker;
      logic [LEN_W-1:0]     bucket_length;
      logic [THRESH_W-1:0]  drop_threshold;
      logic [POS_W-1:0]     position;
      logic signed [CW-1:0] low_y;
      logic signed [CW-1:0] high_y;
      logic [CW-1:0]        low_x;
      logic [CW-1:0]        high_x;
      point_type            pending_points[$];
      int                   mismatches;
      int                   samples_taken;
      int                   points_checked;

      function new();
         bucket_length = LEN_W'(1);
         drop_threshold = THRESH_W'(DROP_RESET);
         position = '0;
         low_y = '0;
         high_y = '0;
         low_x = '0;
         high_x = '0;
         mismatches = 0;
         samples_taken = 0;
         points_checked = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_BUCKET_LENGTH: bucket_length = data[LEN_W-1:0];
            CSR_DROP_THRESHOLD: drop_threshold = data[THRESH_W-1:0];
            default: ;
         endcase
      endfunction

      function void take_sample(logic [CW-1:0] x, logic signed [CW-1:0] y, logic last);
         point_type        burst[$];
         point_type        pt;
         logic [LEN_W-1:0] len;
         logic [CW-1:0]    spread;
         len = (bucket_length == '0) ? LEN_W'(1) : bucket_length;
         if (position == '0) begin
            pt = '{x, y, KIND_FIRST, 1'b0};
            burst.insert(burst.size(), pt);
            low_y = y;
            low_x = x;
            high_y = y;
            high_x = x;
         end else begin
            if (y < low_y) begin
               low_y = y;
               low_x = x;
            end
            if (y > high_y) begin
               high_y = y;
               high_x = x;
            end
         end
         position = position + POS_W'(1);
         if (last || position >= len || position == '0) begin
            spread = high_y - low_y;
            if (spread > {1'b0, drop_threshold}) begin
               pt = '{low_x, low_y, KIND_TROUGH, 1'b0};
               burst.insert(burst.size(), pt);
               pt = '{high_x, high_y, KIND_PEAK, 1'b0};
               burst.insert(burst.size(), pt);
            end
            position = '0;
         end
         if (burst.size() > 0) burst[burst.size() - 1].run_end = 1'b1;
         foreach (burst[i]) pending_points.insert(pending_points.size(), burst[i]);
         samples_taken++;
      endfunction

      function void match_point(logic [CW-1:0] x, logic signed [CW-1:0] y, logic [1:0] kind,
                                logic run_end);
         point_type want;
         if (pending_points.size() == 0) begin
            $error("Unexpected point: x %h, y %h, kind %0d", x, y, kind);
            mismatches++;
            return;
         end
         want = pending_points.pop_front();
         points_checked++;
         if (x !== want.x) begin
            $error("point_x mismatch: expected %h, actual %h", want.x, x);
            mismatches++;
         end
         if (y !== want.y) begin
            $error("point_y mismatch: expected %h, actual %h", want.y, y);
            mismatches++;
         end
         if (kind !== want.kind) begin
            $error("point_kind mismatch: expected %0d, actual %0d", want.kind, kind);
            mismatches++;
         end
         if (run_end !== want.run_end) begin
            $error("run_end mismatch: expected %0d, actual %0d", want.run_end, run_end);
            mismatches++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   bit                     send_steady = 1'b0;
   bit                     drain_steady = 1'b0;
   int                     stall_left = 0;
   int                     settings = 0;
   bucket_tracker          tracker;

   mmbd_req_if #(.COORD_WIDTH(CW)) req_if ();
   mmbd_rsp_if #(.COORD_WIDTH(CW)) rsp_if ();

   min_max_bucket_downsampler_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            tracker.match_point(rsp_if.point_x, rsp_if.point_y, rsp_if.point_kind,
                                rsp_if.run_end);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (!drain_steady && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic send_sample(input logic [CW-1:0] x, input logic [CW-1:0] y, input logic last);
      int gap;
      gap = send_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.sample_x <= x;
      req_if.sample_y <= y;
      req_if.last_sample <= last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      tracker.take_sample(x, y, last);
   endtask

   task automatic settle();
      int waited;
      waited = 0;
      req_if.valid <= 1'b0;
      while (tracker.pending_points.size() > 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      tracker.set_register(index, data);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_bucket(input logic [LEN_W-1:0] len, input logic [THRESH_W-1:0] drop);
      logic [CSR_DATA_W-1:0] upper;
      upper = CSR_DATA_W'($urandom);
      write_reg(CSR_BUCKET_LENGTH, {upper[CSR_DATA_W-1:LEN_W], len});
      write_reg(CSR_DROP_THRESHOLD, drop);
      settings++;
   endtask

   initial begin
      logic [LEN_W-1:0]    len;
      logic [THRESH_W-1:0] drop;
      logic [CW-1:0]       base_y;
      logic [CW-1:0]       y;
      int                  window;
      int                  last_pct;
      tracker = new();
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.sample_x = '0;
      req_if.sample_y = '0;
      req_if.last_sample = 1'b0;
      rsp_if.ready = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values: every sample is a bucket of its own.
      send_sample(32'h0000_0000, 32'h8000_0000, 1'b0);
      send_sample(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1);
      settle();

      // Equal y values keep the earlier sample as trough and peak.
      program_bucket(16'd4, '0);
      send_sample(32'd10, 32'sd5, 1'b0);
      send_sample(32'd11, 32'sd5, 1'b0);
      send_sample(32'd12, 32'sd3, 1'b0);
      send_sample(32'd13, 32'sd3, 1'b0);
      settle();

      program_bucket(16'd0, '0);
      send_sample(32'd20, 32'hFFFF_0000, 1'b0);
      send_sample(32'd21, 32'h0001_0000, 1'b0);
      settle();

      // Full-scale range against the largest threshold, then a range equal to it.
      program_bucket(16'd8, DROP_MAX);
      send_sample(32'd30, 32'h8000_0000, 1'b0);
      send_sample(32'd31, 32'h7FFF_FFFF, 1'b1);
      send_sample(32'd32, 32'h0000_0000, 1'b0);
      send_sample(32'd33, 32'h7FFF_FFFF, 1'b1);
      settle();

      // The bucket length is lowered while a bucket is open.
      program_bucket(16'd6, '0);
      send_sample(32'd40, 32'sd100, 1'b0);
      send_sample(32'd41, -32'sd100, 1'b0);
      send_sample(32'd42, 32'sd7, 1'b0);
      settle();
      program_bucket(16'd2, '0);
      send_sample(32'd43, 32'sd200, 1'b0);
      settle();

      write_reg(CSR_SPARE_A, CSR_DATA_W'($urandom));
      write_reg(CSR_SPARE_B, CSR_DATA_W'($urandom));
      program_bucket(16'd3, 31'd10);
      send_sample(32'd50, 32'sd0, 1'b0);
      send_sample(32'd51, 32'sd10, 1'b0);
      send_sample(32'd52, 32'sd11, 1'b0);
      settle();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               len = 16'd1; drop = THRESH_W'($urandom); window = 0; last_pct = 5;
            end
            1: begin len = 16'hFFFF; drop = '0; window = 1000; last_pct = 4; end
            2: begin len = 16'd2; drop = DROP_MAX; window = 0; last_pct = 10; end
            3: begin
               len = LEN_W'($urandom_range(3, 12));
               drop = THRESH_W'($urandom_range(0, 1 << 20));
               window = 1 << 21;
               last_pct = 5;
            end
            4: begin
               len = LEN_W'($urandom_range(1, 40)); drop = '0; window = 3; last_pct = 5;
            end
            5: begin
               len = LEN_W'($urandom_range(1, 8)); drop = THRESH_W'($urandom);
               window = 0; last_pct = 10;
            end
            default: begin len = 16'd0; drop = '0; window = 0; last_pct = 50; end
         endcase
         send_steady = ($urandom_range(0, 3) == 0);
         drain_steady = ($urandom_range(0, 3) == 0);
         base_y = $urandom;
         settle();
         program_bucket(len, drop);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            y = (window == 0) ? CW'($urandom) : base_y + CW'($urandom_range(0, window));
            send_sample($urandom, y, $urandom_range(0, 99) < last_pct);
         end
      end
      settle();

      if (tracker.pending_points.size() > 0) begin
         $error("%0d expected points never arrived", tracker.pending_points.size());
         tracker.mismatches++;
      end
      $display("Checked %0d points from %0d samples over %0d bucket and threshold settings,",
               tracker.points_checked, tracker.samples_taken, settings);
      $display("with random gaps and stalls on both channels.");
      if (tracker.mismatches == 0) begin
         $display("PASS min_max_bucket_downsampler_core");
      end else begin
         $display("FAIL min_max_bucket_downsampler_core");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("FAIL min_max_bucket_downsampler_core");
      $finish;
   end

endmodule

// ===== min_max_bucket_downsampler_core.f =====
rtl/core/mmbd_pkg.sv
rtl/core/mmbd_if.sv
rtl/core/mmbd_front.sv
rtl/core/mmbd_queue.sv
rtl/core/mmbd_back.sv
rtl/core/min_max_bucket_downsampler_core.sv
rtl/core/mmbd_checker.sv
dv/min_max_bucket_downsampler_core_test.sv
